// ===== hdl/sha512_hash_engine_core_assert.svh =====
// Assertion macros shared by the SHA-512 engine checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SHA512_HASH_ENGINE_CORE_ASSERT_SVH
`define SHA512_HASH_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHA512_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha512 engine check failed");

// Next-cycle implication, disabled during reset.
`define SHA512_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha512 engine check failed");

`endif

// ===== hdl/sha512_pkg.sv =====
// Shared types, constants and round functions of the SHA-512 engine.
// Used by the controller, the datapath and the top level.
`default_nettype none
package sha512_pkg;

  localparam int BLOCK_BYTES = 128;
  localparam int LEN_POS     = 112;
  localparam int ROUNDS      = 80;

  // Block kinds the controller tracks through a compression.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PAD1  = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       wr_byte;
    logic       pad;
    logic       len;
    logic       init;
    logic       round;
    logic       add;
    logic       clear;
    logic [6:0] rnd;
    logic [2:0] word_idx;
  } sha512_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;
    logic pad_two;
  } sha512_sts_t;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] big_s0(input logic [63:0] x);
    return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
  endfunction

  function automatic logic [63:0] big_s1(input logic [63:0] x);
    return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
  endfunction

  function automatic logic [63:0] small_s0(input logic [63:0] x);
    return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ {7'd0, x[63:7]};
  endfunction

  function automatic logic [63:0] small_s1(input logic [63:0] x);
    return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ {6'd0, x[63:6]};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sha512_ifs.sv =====
// Valid/ready channel interfaces for message bytes and digest words.
// Standalone; no package dependency.
`default_nettype none
interface sha512_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== hdl/sha512_dp.sv =====
// SHA-512 datapath: block buffer and schedule window, round variables,
// hash state and length count. Depends on sha512_pkg.
`default_nettype none
module sha512_dp (
  input  wire                     clk,
  input  wire                     rst_n,
  input  sha512_pkg::sha512_cmd_t cmd,
  input  wire [7:0]               data_byte,
  output sha512_pkg::sha512_sts_t sts,
  output logic [63:0]             digest
);
  import sha512_pkg::*;

  logic [63:0]  w_r   [16];
  logic [63:0]  w_nxt [16];
  logic [63:0]  v_r   [8];
  logic [63:0]  v_nxt [8];
  logic [63:0]  h_r   [8];
  logic [63:0]  h_nxt [8];
  logic [6:0]   fill_r, fill_nxt;
  logic [117:0] blk_r, blk_nxt;
  logic [127:0] bit_len;
  logic [63:0]  t1, t2, w_new;

  // The block count sits above the byte count, so the bit length wraps at 2^128.
  assign bit_len = {blk_r, fill_r, 3'b000};
  assign sts.fill_last = (fill_r == 7'(BLOCK_BYTES - 1));
  assign sts.pad_two   = (fill_r >= 7'(LEN_POS));
  assign digest = h_r[cmd.word_idx];

  // Round arithmetic on the current variables and the head of the window.
  assign t1 = v_r[7] + big_s1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + K[cmd.rnd] + w_r[0];
  assign t2 = big_s0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = small_s1(w_r[14]) + w_r[9] + small_s0(w_r[1]) + w_r[0];

  // Block buffer and schedule window.
  always_comb begin
    w_nxt = w_r;
    if (cmd.wr_byte) begin
      for (int j = 0; j < 16; j++) begin
        for (int b = 0; b < 8; b++) begin
          if (7'(j * 8 + b) == fill_r) w_nxt[j][63 - 8 * b -: 8] = data_byte;
        end
      end
    end else if (cmd.pad) begin
      for (int j = 0; j < 16; j++) begin
        for (int b = 0; b < 8; b++) begin
          if (7'(j * 8 + b) == fill_r) begin
            w_nxt[j][63 - 8 * b -: 8] = 8'h80;
          end else if (7'(j * 8 + b) > fill_r) begin
            w_nxt[j][63 - 8 * b -: 8] = 8'h00;
          end
        end
      end
      if (!sts.pad_two) begin
        w_nxt[14] = bit_len[127:64];
        w_nxt[15] = bit_len[63:0];
      end
    end else if (cmd.len) begin
      for (int j = 0; j < 14; j++) w_nxt[j] = '0;
      w_nxt[14] = bit_len[127:64];
      w_nxt[15] = bit_len[63:0];
    end else if (cmd.round) begin
      for (int j = 0; j < 15; j++) w_nxt[j] = w_r[j + 1];
      w_nxt[15] = w_new;
    end
  end

  // Round variables.
  always_comb begin
    v_nxt = v_r;
    if (cmd.init) begin
      v_nxt = h_r;
    end else if (cmd.round) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
  end

  // Hash state, fill count and block count.
  always_comb begin
    h_nxt    = h_r;
    fill_nxt = fill_r;
    blk_nxt  = blk_r;
    if (cmd.clear) begin
      h_nxt    = IV;
      fill_nxt = '0;
      blk_nxt  = '0;
    end else begin
      if (cmd.add) begin
        for (int i = 0; i < 8; i++) h_nxt[i] = h_r[i] + v_r[i];
      end
      if (cmd.wr_byte) begin
        fill_nxt = fill_r + 7'd1;
        if (sts.fill_last) blk_nxt = blk_r + 118'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    v_r <= v_nxt;
    if (!rst_n) begin
      h_r    <= IV;
      fill_r <= '0;
      blk_r  <= '0;
    end else begin
      h_r    <= h_nxt;
      fill_r <= fill_nxt;
      blk_r  <= blk_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sha512_ctrl.sv =====
// SHA-512 controller: sequences byte loading, padding, the 80 rounds and
// the digest output. Depends on sha512_pkg.
`default_nettype none
module sha512_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  wire                     in_has_byte,
  input  wire                     in_end,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [2:0]              out_idx,
  input  sha512_pkg::sha512_sts_t sts,
  output sha512_pkg::sha512_cmd_t cmd
);
  import sha512_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PAD   = 7'b0000010,
    S_LEN   = 7'b0000100,
    S_INIT  = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] rnd_r, rnd_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       end_r, end_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_idx   = idx_r;
  assign acc       = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    rnd_nxt      = rnd_r;
    kind_nxt     = kind_r;
    end_nxt      = end_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.rnd      = rnd_r;
    cmd.word_idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.wr_byte = acc && in_has_byte;
        if (acc && in_has_byte && sts.fill_last) begin
          state_nxt = S_INIT;
          kind_nxt  = KIND_DATA;
          end_nxt   = in_end;
        end else if (acc && in_end) begin
          state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        cmd.pad   = 1'b1;
        kind_nxt  = sts.pad_two ? KIND_PAD1 : KIND_FINAL;
        state_nxt = S_INIT;
      end
      S_LEN: begin
        cmd.len   = 1'b1;
        kind_nxt  = KIND_FINAL;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        rnd_nxt   = '0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + 7'd1;
        if (rnd_r == 7'(ROUNDS - 1)) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        case (kind_r)
          KIND_DATA: begin
            state_nxt = end_r ? S_PAD : S_IDLE;
            end_nxt   = 1'b0;
          end
          KIND_PAD1: state_nxt = S_LEN;
          default: begin
            idx_nxt   = '0;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rnd_r   <= '0;
      kind_r  <= KIND_DATA;
      end_r   <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      kind_r  <= kind_nxt;
      end_r   <= end_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sha512_hash_engine_core.sv =====
// SHA-512 engine taking one message byte per request and returning the digest as
// eight 64-bit words, most significant first, after a request with end_of_message.
// A byte request is taken while the engine is idle; the request that completes a
// 128-byte block holds off input for the load, the 80 rounds, one per cycle, and
// the hash update, set by the single shared round unit. Ending a message costs
// a padding step and one compression, plus a second compression of the length
// block when 112 or more bytes are held, and then the eight digest words, one per
// accepted output request. Input is not accepted while the digest is being
// delivered. Depends on sha512_pkg and the channel interfaces.
`default_nettype none
module sha512_hash_engine_core (
  input wire           clk,
  input wire           rst_n,
  sha512_in_if.sink    in_ch,
  sha512_out_if.source out_ch
);
  import sha512_pkg::*;

  sha512_cmd_t cmd;
  sha512_sts_t sts;
  logic [2:0]  idx;
  logic [63:0] digest;

  // Controller.
  sha512_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_has_byte (in_ch.has_byte),
    .in_end      (in_ch.end_of_message),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_idx     (idx),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Datapath.
  sha512_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .data_byte (in_ch.data_byte),
    .sts       (sts),
    .digest    (digest)
  );

  // Digest word payload.
  assign out_ch.digest_word = digest;
  assign out_ch.word_index  = idx;
  assign out_ch.last_word   = (idx == 3'd7);

endmodule
`default_nettype wire

// ===== hdl/sha512_hash_engine_core_chk.sv =====
// Port-level checker for the SHA-512 engine, bound to the top level.
// Depends on the assertion macro header.
`default_nettype none
`include "sha512_hash_engine_core_assert.svh"
module sha512_hash_engine_core_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [2:0] out_word_index,
  input wire       out_last_word
);

  // The last flag marks exactly the eighth word.
  `SHA512_ASSERT_IMP(a_last_idx, out_valid, out_last_word == (out_word_index == 3'd7))

  // Words follow each other in order without a gap.
  `SHA512_ASSERT_NXT(a_idx_step, out_valid && out_ready && !out_last_word, out_valid && (out_word_index == 3'($past(out_word_index) + 3'd1)))

  // No request is taken while a digest is being delivered.
  `SHA512_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)

  // A digest starts at the most significant word.
  `SHA512_ASSERT_IMP(a_first_word, $rose(out_valid), out_word_index == 3'd0)

endmodule

bind sha512_hash_engine_core sha512_hash_engine_core_chk u_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_word_index (out_ch.word_index),
  .out_last_word  (out_ch.last_word)
);
`default_nettype wire

// ===== tb/sha512_hash_engine_core_tb.sv =====
// Testbench for the SHA-512 hash engine: byte requests in, eight digest words out.
// Predicts each digest with its own SHA-512 model and checks every word in order.
// Depends on sha512_pkg (round constants, IV) and the channel interfaces.
module sha512_hash_engine_core_tb;
  import sha512_pkg::*;

  logic clk;
  logic rst_n;

  sha512_in_if  in_ch ();
  sha512_out_if out_ch ();

  sha512_hash_engine_core i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  // Predictor state.
  logic [7:0]   msg_buf [128];
  logic [7:0]   buf_fill;
  logic [127:0] msg_bits;
  logic [63:0]  chain [8];

  digest_word_t digest_q [$];
  int           mismatch_cnt;
  int           words_seen;
  bit           rx_hold;
  int           hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("sha512_hash_engine_core test failed");
    $finish;
  end

  function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // One SHA-512 compression of msg_buf into chain.
  task automatic compress_block();
    logic [63:0] w [16];
    logic [63:0] v [8];
    logic [63:0] wr, s0, s1, t1, t2, w2, w15;
    for (int i = 0; i < 16; i++) begin
      w[i] = '0;
      for (int b = 0; b < 8; b++) w[i] = {w[i][55:0], msg_buf[i*8+b]};
    end
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        w2  = w[(r-2)&15];
        w15 = w[(r-15)&15];
        s1 = ror64(w2, 19) ^ ror64(w2, 61) ^ (w2 >> 6);
        s0 = ror64(w15, 1) ^ ror64(w15, 8) ^ (w15 >> 7);
        wr = s1 + w[(r-7)&15] + s0 + w[r&15];
        w[r&15] = wr;
      end
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[r] + wr;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int i = 7; i > 0; i--) v[i] = v[i-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
  endtask

  task automatic reset_predictor();
    buf_fill = '0;
    msg_bits = '0;
    for (int i = 0; i < 8; i++) chain[i] = IV[i];
  endtask

  // Apply one accepted request to the predictor and queue any digest words.
  task automatic predict_request(input logic [7:0] b, input logic hb, input logic eom);
    int n;
    digest_word_t dw;
    if (hb) begin
      msg_buf[buf_fill[6:0]] = b;
      buf_fill = {1'b0, buf_fill[6:0]} + 8'd1;
      if (buf_fill >= 8'd128) begin
        compress_block();
        msg_bits = msg_bits + 128'd1024;
        buf_fill = '0;
      end
    end
    if (eom) begin
      n = buf_fill[6:0];
      msg_bits = msg_bits + 128'(n * 8);
      msg_buf[n] = 8'h80;
      for (int i = n + 1; i < 128; i++) msg_buf[i] = 8'h00;
      if (n >= LEN_POS) begin
        compress_block();
        for (int i = 0; i < 128; i++) msg_buf[i] = 8'h00;
      end
      for (int i = 0; i < 16; i++) msg_buf[LEN_POS+i] = msg_bits[127-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        dw.digest_word = chain[i];
        dw.word_index  = 3'(i);
        dw.last_word   = (i == 7);
        digest_q.push_back(dw);
      end
      reset_predictor();
    end
  endtask

  // Send one request after a random gap, then predict it once accepted.
  // The request stays offered after acceptance until the next one or a drain.
  task automatic send_request(input logic [7:0] b, input logic hb, input logic eom,
                              input bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.has_byte       <= hb;
    in_ch.end_of_message <= eom;
    do @(posedge clk); while (!in_ch.ready);
    predict_request(b, hb, eom);
  endtask

  task automatic send_message(input int len, input bit end_with_byte);
    for (int i = 0; i < len; i++) begin
      send_request(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
    end
    if (!end_with_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stop offering requests and wait until every predicted word has come.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
  endtask

  // Empty message, extreme bytes, both flag combinations, idle requests.
  task automatic test_directed();
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h55, 1'b0, 1'b0);
    send_request(8'haa, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
  endtask

  // A whole block followed by 112 more bytes: the data block is compressed
  // mid-message and the padding then spills into a second block.
  task automatic test_block_edges();
    send_message(240, 1);
  endtask

  // The receiver holds off long while the sender keeps pushing.
  task automatic test_backpressure();
    hold_cycles = 400;
    rx_hold = 1'b1;
    send_message(3, 1);
    send_message(2, 1);
    send_message(1, 0);
    wait_drained();
  endtask

  // Short random messages with occasional idle requests.
  task automatic test_random();
    int len;
    for (int m = 0; m < 8; m++) begin
      len = $urandom_range(0, 4);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) send_request(8'($urandom), 1'b0, 1'b0);
        send_request(8'($urandom), 1'b1, 1'b0, 1'($urandom_range(0, 1)));
      end
      send_request(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  // Output side: a random wait before each word, long hold on request.
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        rx_hold = 1'b0;
      end else begin
        wait_n = $urandom_range(0, 14);
        if (wait_n != 0) begin
          out_ch.ready <= 1'b0;
          repeat (wait_n) @(negedge clk);
        end
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (!out_ch.valid);
        @(negedge clk);
      end
    end
  end

  // Compare each accepted digest word with the oldest prediction.
  initial begin
    digest_word_t exp_w;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        words_seen++;
        if (digest_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected digest word %h", out_ch.digest_word);
        end else begin
          exp_w = digest_q.pop_front();
          if (exp_w.digest_word !== out_ch.digest_word ||
              exp_w.word_index !== out_ch.word_index ||
              exp_w.last_word !== out_ch.last_word) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                       exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                       out_ch.digest_word, out_ch.word_index, out_ch.last_word);
          end
        end
      end
    end
  end

  initial begin
    mismatch_cnt = 0;
    words_seen   = 0;
    rx_hold      = 1'b0;
    hold_cycles  = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.has_byte = 1'b0;
    in_ch.end_of_message = 1'b0;
    reset_predictor();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_block_edges();
    wait_drained();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (300) @(negedge clk);
    if (mismatch_cnt == 0 && digest_q.size() == 0) begin
      $display("sha512_hash_engine_core test passed");
    end else begin
      $display("sha512_hash_engine_core test failed");
    end
    $finish;
  end
endmodule

// ===== sha512_hash_engine_core.f =====
+incdir+hdl
hdl/sha512_pkg.sv
hdl/sha512_ifs.sv
hdl/sha512_dp.sv
hdl/sha512_ctrl.sv
hdl/sha512_hash_engine_core.sv
hdl/sha512_hash_engine_core_chk.sv
tb/sha512_hash_engine_core_tb.sv
